// File: hw/rtl/lnf_pkg.sv
// ----------------------------------------------------------------------------
// lnf_pkg
// Shared types and constants for the layer normalization forward unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lnf_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SLICE_LENGTH = 2'd0;
  localparam logic [1:0] REG_AFFINE       = 2'd1;
  localparam logic [1:0] REG_EPSILON      = 2'd2;

  // configuration reset values
  localparam logic [6:0]  SLICE_LENGTH_RST = 7'd64;
  localparam logic        AFFINE_RST       = 1'b1;
  localparam logic [15:0] EPSILON_RST      = 16'd1;

  // shared divider: dividend and divisor widths
  localparam int DIV_W = 49;
  localparam int DEN_W = 34;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd49;

  // reciprocal square root
  localparam int RSTD_W = 25;
  localparam logic [RSTD_W-1:0] RSTD_ONE = 25'h1000000;
  localparam logic [31:0]       RSTD_SAT = 32'hFFFF_FFFF;
  localparam logic [4:0]        RSTD_TOP_BIT = 5'd24;

  // output datapath accumulator width
  localparam int ACC_W = 60;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MDIV = 7'b0000010,
    S_VAR  = 7'b0000100,
    S_VDIV = 7'b0001000,
    S_QDIV = 7'b0010000,
    S_SQRT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage

// File: hw/rtl/lnf_ram.sv
// ----------------------------------------------------------------------------
// lnf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/layer_norm_forward_unit.sv
// ----------------------------------------------------------------------------
// layer_norm_forward_unit
// Fixed-point layer normalization: buffers one slice, then mean, variance,
// reciprocal sqrt, and one normalized result per stored element.
// ----------------------------------------------------------------------------
// Load: one element per cycle while busy is low; only the slice-closing
//   element raises busy.
// After the closing element, busy stays high through three divisions (mean,
//   variance, reciprocal), a 25-bit root search that squares and compares each
//   candidate bit, and two passes over the element RAM (variance, output); the
//   reciprocal division and root search are skipped when variance plus epsilon
//   is zero. Results stream one per cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears counters, sum and sequencer and loads
//   register defaults; element RAM contents are not cleared.
`timescale 1ns / 1ps

module layer_norm_forward_unit #(
  parameter int MAX_LENGTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_sample,
  input  logic signed [15:0] in_gain,
  input  logic signed [15:0] in_offset,
  // result transactions
  output logic               out_valid,
  output logic signed [15:0] out_normalized,
  output logic signed [15:0] out_mean,
  output logic [31:0]        out_recip_std,
  output logic               out_last,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CW  = $clog2(MAX_LENGTH + 1);
  localparam int SW  = 17 + CW;
  localparam int NW  = SW + 2;
  localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LENGTH);

  localparam int DW = lnf_pkg::DIV_W;
  localparam int EW = lnf_pkg::DEN_W;
  localparam int RW = lnf_pkg::RSTD_W;
  localparam int XW = lnf_pkg::ACC_W;
  localparam int TW = lnf_pkg::DIV_CNT_W;

  // --------------------------------------------------------------------------
  // configuration registers
  logic [6:0]  slice_length_r;
  logic        affine_r;
  logic [15:0] epsilon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_length_r <= lnf_pkg::SLICE_LENGTH_RST;
      affine_r       <= lnf_pkg::AFFINE_RST;
      epsilon_r      <= lnf_pkg::EPSILON_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lnf_pkg::REG_SLICE_LENGTH: slice_length_r <= cfg_data[6:0];
        lnf_pkg::REG_AFFINE:       affine_r       <= cfg_data[0];
        lnf_pkg::REG_EPSILON:      epsilon_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped slice length
  logic [CW-1:0] len;
  always_comb begin
    if (slice_length_r == 7'd0) begin
      len = CW'(1);
    end else if (32'(slice_length_r) > MAX_LENGTH) begin
      len = MAX_LEN_C;
    end else begin
      len = CW'(slice_length_r);
    end
  end

  // --------------------------------------------------------------------------
  // state
  lnf_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [CW-1:0]        n_r, n_nxt;

  // shared divider
  logic [DW-1:0]            div_num_r, div_num_nxt;
  logic [EW-1:0]            div_den_r, div_den_nxt;
  logic [EW:0]              div_rem_r, div_rem_nxt;
  logic [TW-1:0]            div_cnt_r, div_cnt_nxt;
  logic                     mean_neg_r, mean_neg_nxt;

  // slice statistics
  logic signed [15:0] mean_r, mean_nxt;
  logic [DW-1:0]      sumsq_r, sumsq_nxt;
  logic [DW-1:0]      q2_r, q2_nxt;
  logic [RW-1:0]      root_r, root_nxt;
  logic [4:0]         bit_r, bit_nxt;
  logic               phase_r, phase_nxt;
  logic [2*RW-1:0]    sqr_r, sqr_nxt;
  logic [RW-1:0]      rstd_use_r, rstd_use_nxt;
  logic [31:0]        rstd_out_r, rstd_out_nxt;

  // pass pipeline
  logic [CW-1:0] issue_r, issue_nxt;
  logic          rv_r, p1_v_r, p2_v_r;
  logic          rv_last_r, p1_last_r, p2_last_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != lnf_pkg::S_IDLE);

  // --------------------------------------------------------------------------
  // element RAM: {sample, gain, offset}
  logic [AW-1:0] ram_raddr;
  logic [47:0]   ram_rdata;

  lnf_ram #(
    .WIDTH (48),
    .DEPTH (MAX_LENGTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_sample, in_gain, in_offset}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic signed [15:0] rd_sample, rd_gain, rd_offset;
  assign rd_sample = ram_rdata[47:32];
  assign rd_gain   = ram_rdata[31:16];
  assign rd_offset = ram_rdata[15:0];

  logic issue_active;
  assign issue_active = ((state_r == lnf_pkg::S_VAR) || (state_r == lnf_pkg::S_OUT)) &&
                        (issue_r < n_r);
  assign ram_raddr = issue_r[AW-1:0];

  // --------------------------------------------------------------------------
  // divider step: one quotient bit per cycle
  logic [EW:0]   div_rem_sh;
  logic          div_ge;
  logic [EW:0]   div_rem_step;
  logic [DW-1:0] div_num_step;

  always_comb begin
    div_rem_sh   = {div_rem_r[EW-1:0], div_num_r[DW-1]};
    div_ge       = (div_rem_sh >= {1'b0, div_den_r});
    div_rem_step = div_ge ? (div_rem_sh - {1'b0, div_den_r}) : div_rem_sh;
    div_num_step = {div_num_r[DW-2:0], div_ge};
  end

  // mean from quotient, floor semantics and saturation
  logic signed [DW+1:0] mean_mag;
  logic signed [DW+1:0] mean_full;
  logic signed [15:0]   mean_sat;

  always_comb begin
    mean_mag = $signed({2'b00, div_num_r}) +
               $signed((DW+2)'(mean_neg_r && (div_rem_r != '0)));
    mean_full = mean_neg_r ? -mean_mag : mean_mag;
    if (mean_full > $signed((DW+2)'(32767))) begin
      mean_sat = 16'sh7FFF;
    end else if (mean_full < -$signed((DW+2)'(32768))) begin
      mean_sat = -16'sh8000;
    end else begin
      mean_sat = mean_full[15:0];
    end
  end

  // accept path: numerator for the mean division
  logic [CW-1:0]        n_acc;
  logic signed [NW-1:0] mean_num;
  logic [NW-1:0]        mean_num_mag;

  always_comb begin
    n_acc        = count_r + CW'(1);
    sum_nxt      = sum_r + SW'(in_sample);
    mean_num     = ($signed(NW'(sum_nxt)) <<< 1) + $signed(NW'({1'b0, n_acc}));
    mean_num_mag = mean_num[NW-1] ? NW'(-mean_num) : NW'(mean_num);
  end

  // variance plus epsilon from quotient
  logic [EW-1:0] var_eps;
  assign var_eps = div_num_r[EW-1:0] + EW'(epsilon_r);

  // root search candidate
  logic [RW-1:0] root_try;
  assign root_try = root_r | (RW'(1) << bit_r);

  // --------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    div_num_nxt  = div_num_r;
    div_den_nxt  = div_den_r;
    div_rem_nxt  = div_rem_r;
    div_cnt_nxt  = div_cnt_r;
    mean_neg_nxt = mean_neg_r;
    mean_nxt     = mean_r;
    q2_nxt       = q2_r;
    root_nxt     = root_r;
    bit_nxt      = bit_r;
    phase_nxt    = phase_r;
    sqr_nxt      = sqr_r;
    rstd_use_nxt = rstd_use_r;
    rstd_out_nxt = rstd_out_r;
    issue_nxt    = issue_active ? issue_r + CW'(1) : issue_r;

    case (state_r)
      lnf_pkg::S_IDLE: begin
        if (accept) begin
          if (n_acc >= len) begin
            n_nxt        = n_acc;
            count_nxt    = '0;
            mean_neg_nxt = mean_num[NW-1];
            div_num_nxt  = DW'(mean_num_mag);
            div_den_nxt  = EW'({n_acc, 1'b0});
            div_rem_nxt  = '0;
            div_cnt_nxt  = lnf_pkg::DIV_STEPS;
            state_nxt    = lnf_pkg::S_MDIV;
          end else begin
            count_nxt = n_acc;
          end
        end
      end

      lnf_pkg::S_MDIV: begin
        if (div_cnt_r != '0) begin
          div_num_nxt = div_num_step;
          div_rem_nxt = div_rem_step;
          div_cnt_nxt = div_cnt_r - TW'(1);
        end else begin
          mean_nxt  = mean_sat;
          issue_nxt = '0;
          state_nxt = lnf_pkg::S_VAR;
        end
      end

      lnf_pkg::S_VAR: begin
        if (!issue_active && !rv_r && !p1_v_r && !p2_v_r) begin
          div_num_nxt = sumsq_r;
          div_den_nxt = EW'(n_r);
          div_rem_nxt = '0;
          div_cnt_nxt = lnf_pkg::DIV_STEPS;
          state_nxt   = lnf_pkg::S_VDIV;
        end
      end

      lnf_pkg::S_VDIV: begin
        if (div_cnt_r != '0) begin
          div_num_nxt = div_num_step;
          div_rem_nxt = div_rem_step;
          div_cnt_nxt = div_cnt_r - TW'(1);
        end else if (var_eps == '0) begin
          // zero variance, zero epsilon
          rstd_use_nxt = lnf_pkg::RSTD_ONE;
          rstd_out_nxt = lnf_pkg::RSTD_SAT;
          issue_nxt    = '0;
          state_nxt    = lnf_pkg::S_OUT;
        end else begin
          div_num_nxt = DW'(1) << (DW - 1);
          div_den_nxt = var_eps;
          div_rem_nxt = '0;
          div_cnt_nxt = lnf_pkg::DIV_STEPS;
          state_nxt   = lnf_pkg::S_QDIV;
        end
      end

      lnf_pkg::S_QDIV: begin
        if (div_cnt_r != '0) begin
          div_num_nxt = div_num_step;
          div_rem_nxt = div_rem_step;
          div_cnt_nxt = div_cnt_r - TW'(1);
        end else begin
          q2_nxt    = div_num_r;
          root_nxt  = '0;
          bit_nxt   = lnf_pkg::RSTD_TOP_BIT;
          phase_nxt = 1'b0;
          state_nxt = lnf_pkg::S_SQRT;
        end
      end

      lnf_pkg::S_SQRT: begin
        // square the candidate, then compare in the next cycle
        if (!phase_r) begin
          sqr_nxt   = root_try * root_try;
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (sqr_r <= {1'b0, q2_r}) begin
            root_nxt = root_try;
          end
          if (bit_r == '0) begin
            rstd_use_nxt = (sqr_r <= {1'b0, q2_r}) ? root_try : root_r;
            rstd_out_nxt = 32'(rstd_use_nxt);
            issue_nxt    = '0;
            state_nxt    = lnf_pkg::S_OUT;
          end else begin
            bit_nxt = bit_r - 5'd1;
          end
        end
      end

      lnf_pkg::S_OUT: begin
        if (!issue_active && !rv_r && !p1_v_r && !p2_v_r) begin
          state_nxt = lnf_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lnf_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lnf_pkg::S_IDLE;
      count_r <= '0;
      sum_r   <= '0;
      issue_r <= '0;
      rv_r    <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      issue_r <= issue_nxt;
      if (accept) begin
        sum_r <= (n_acc >= len) ? '0 : sum_nxt;
      end
      rv_r   <= issue_active;
      p1_v_r <= rv_r;
      p2_v_r <= p1_v_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    div_num_r  <= div_num_nxt;
    div_den_r  <= div_den_nxt;
    div_rem_r  <= div_rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    mean_neg_r <= mean_neg_nxt;
    mean_r     <= mean_nxt;
    q2_r       <= q2_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    phase_r    <= phase_nxt;
    sqr_r      <= sqr_nxt;
    rstd_use_r <= rstd_use_nxt;
    rstd_out_r <= rstd_out_nxt;
    rv_last_r  <= (issue_r == n_r - CW'(1));
    p1_last_r  <= rv_last_r;
    p2_last_r  <= p1_last_r;
  end

  // --------------------------------------------------------------------------
  // pass datapath: deviation, then square (variance) or scale (output)
  logic signed [16:0] dev;
  assign dev = 17'(rd_sample) - 17'(mean_r);

  logic signed [16:0] d_r;
  logic signed [32:0] m_r;
  logic signed [15:0] off1_r, off2_r;
  logic [33:0]        sq_r;
  logic signed [46:0] pp_hi_r;
  logic signed [45:0] pp_lo_r;

  always_ff @(posedge clk) begin
    // stage 1
    d_r    <= dev;
    m_r    <= affine_r ? 33'(dev * rd_gain) : 33'(dev);
    off1_r <= rd_offset;
    // stage 2
    sq_r    <= 34'(d_r * d_r);
    pp_hi_r <= m_r * $signed({1'b0, rstd_use_r[RW-1:12]});
    pp_lo_r <= m_r * $signed({1'b0, rstd_use_r[11:0]});
    off2_r  <= off1_r;
  end

  // sum of squares accumulates in the variance pass
  always_comb begin
    sumsq_nxt = sumsq_r;
    if (state_r == lnf_pkg::S_MDIV) begin
      sumsq_nxt = '0;
    end else if ((state_r == lnf_pkg::S_VAR) && p2_v_r) begin
      sumsq_nxt = sumsq_r + DW'(sq_r);
    end
  end

  always_ff @(posedge clk) begin
    sumsq_r <= sumsq_nxt;
  end

  // final sum, rounding and saturation
  logic signed [XW-1:0] acc;
  logic signed [XW-1:0] acc_rnd;
  logic signed [XW-1:0] y_full;
  logic signed [15:0]   y_sat;

  always_comb begin
    acc = ($signed(XW'(pp_hi_r)) <<< 12) + $signed(XW'(pp_lo_r));
    if (affine_r) begin
      acc     = acc + ($signed(XW'(off2_r)) <<< 24);
      acc_rnd = acc + $signed(XW'(1) <<< 23);
      y_full  = acc_rnd >>> 24;
    end else begin
      acc_rnd = acc + $signed(XW'(1) <<< 15);
      y_full  = acc_rnd >>> 16;
    end
    if (y_full > $signed(XW'(32767))) begin
      y_sat = 16'sh7FFF;
    end else if (y_full < -$signed(XW'(32768))) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_full[15:0];
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p2_v_r && (state_r == lnf_pkg::S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    out_normalized <= y_sat;
    out_mean       <= mean_r;
    out_recip_std  <= rstd_out_r;
    out_last       <= p2_last_r;
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // assertions
  a_out_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside the output pass");

  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (n_acc >= len)) |=> busy)
    else $error("slice close did not start processing");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result follows the last result of a slice");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (count_r < MAX_LEN_C))
    else $error("element count out of range");

endmodule
